>>> sv/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared sizes, control word layout and result codes of the value search
// cache with fifo fill.
// ----------------------------------------------------------------------------
`default_nettype none

package vsc_pkg;

  // geometry
  localparam int MEM_WORDS   = 128;
  localparam int BLOCK_WORDS = 4;
  localparam int CACHE_SLOTS = 4;
  localparam int CACHE_WORDS = CACHE_SLOTS * BLOCK_WORDS;
  localparam int NUM_BLOCKS  = (MEM_WORDS + BLOCK_WORDS - 1) / BLOCK_WORDS;

  // field widths
  localparam int DATA_W = 32;
  localparam int ADDR_W = 7;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;
  localparam int BLK_W  = 5;
  localparam int SLOT_W = 2;

  // derived widths
  localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int CAW = (CACHE_WORDS > 1) ? $clog2(CACHE_WORDS) : 1;
  localparam int SW  = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int BWW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int GW  = $clog2(NUM_BLOCKS + CACHE_SLOTS + 1);
  localparam int IW  = $clog2(MEM_WORDS + BLOCK_WORDS + CACHE_WORDS);

  // match count saturation
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // microprogram counter width
  localparam int UPC_W = 4;

  typedef enum logic [STAT_W-1:0] {
    ST_WRITE    = 2'd0,
    ST_HIT      = 2'd1,
    ST_FILLED   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NOSTART,
    C_WRITE,
    C_HIT,
    C_MATCH,
    C_NOMATCH
  } cond_e;

  typedef enum logic [1:0] {
    INIT_NONE,
    INIT_CACHE,
    INIT_MEM,
    INIT_FILL
  } init_e;

  // one control word of the microprogram
  typedef struct packed {
    cond_e             cond;
    logic [UPC_W-1:0]  jmp;
    logic              hold;
    init_e             init;
    logic              rd_cache;
    logic              cmp_cache;
    logic              rd_mem;
    logic              cmp_mem;
    logic              rd_fill;
    logic              wr_fill;
    logic              wr_back;
    logic              commit;
    logic              emit;
    status_e           code;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic is_write;
    logic hit;
    logic match;
    logic last;
  } flags_t;

endpackage

`default_nettype wire

>>> sv/vsc_ram.sv
// ----------------------------------------------------------------------------
// vsc_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/vsc_seq.sv
// ----------------------------------------------------------------------------
// vsc_seq
// Microprogram store and step counter: one control word per step, with
// conditional jumps and a hold that repeats a step until a scan ends.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire vsc_pkg::flags_t flags_i,
  output      vsc_pkg::ctrl_t  ctrl_o,
  output      logic            busy_o
);

  import vsc_pkg::*;

  // step addresses
  localparam logic [UPC_W-1:0] U_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] U_DISP  = 4'd1;
  localparam logic [UPC_W-1:0] U_CSCAN = 4'd2;
  localparam logic [UPC_W-1:0] U_CTAIL = 4'd3;
  localparam logic [UPC_W-1:0] U_CDEC  = 4'd4;
  localparam logic [UPC_W-1:0] U_MSCAN = 4'd5;
  localparam logic [UPC_W-1:0] U_MTAIL = 4'd6;
  localparam logic [UPC_W-1:0] U_FINIT = 4'd7;
  localparam logic [UPC_W-1:0] U_FCOPY = 4'd8;
  localparam logic [UPC_W-1:0] U_FTAIL = 4'd9;
  localparam logic [UPC_W-1:0] U_WR    = 4'd10;
  localparam logic [UPC_W-1:0] U_HIT   = 4'd11;
  localparam logic [UPC_W-1:0] U_NF    = 4'd12;

  function automatic ctrl_t ucode(logic [UPC_W-1:0] a);
    ctrl_t c;
    c = '0;
    case (a)
      U_IDLE: begin
        c.cond = C_NOSTART;
        c.jmp  = U_IDLE;
      end
      U_DISP: begin
        c.init = INIT_CACHE;
        c.cond = C_WRITE;
        c.jmp  = U_WR;
      end
      U_CSCAN: begin
        c.rd_cache  = 1'b1;
        c.cmp_cache = 1'b1;
        c.hold      = 1'b1;
      end
      U_CTAIL: begin
        c.cmp_cache = 1'b1;
      end
      U_CDEC: begin
        c.init = INIT_MEM;
        c.cond = C_HIT;
        c.jmp  = U_HIT;
      end
      U_MSCAN: begin
        c.rd_mem  = 1'b1;
        c.cmp_mem = 1'b1;
        c.hold    = 1'b1;
        c.cond    = C_MATCH;
        c.jmp     = U_FINIT;
      end
      U_MTAIL: begin
        c.cmp_mem = 1'b1;
        c.cond    = C_NOMATCH;
        c.jmp     = U_NF;
      end
      U_FINIT: begin
        c.init = INIT_FILL;
      end
      U_FCOPY: begin
        c.rd_fill = 1'b1;
        c.wr_fill = 1'b1;
        c.hold    = 1'b1;
      end
      U_FTAIL: begin
        c.wr_fill = 1'b1;
        c.commit  = 1'b1;
        c.emit    = 1'b1;
        c.code    = ST_FILLED;
        c.cond    = C_ALWAYS;
        c.jmp     = U_IDLE;
      end
      U_WR: begin
        c.wr_back = 1'b1;
        c.emit    = 1'b1;
        c.code    = ST_WRITE;
        c.cond    = C_ALWAYS;
        c.jmp     = U_IDLE;
      end
      U_HIT: begin
        c.emit = 1'b1;
        c.code = ST_HIT;
        c.cond = C_ALWAYS;
        c.jmp  = U_IDLE;
      end
      U_NF: begin
        c.emit = 1'b1;
        c.code = ST_NOTFOUND;
        c.cond = C_ALWAYS;
        c.jmp  = U_IDLE;
      end
      default: begin
        c.cond = C_ALWAYS;
        c.jmp  = U_IDLE;
      end
    endcase
    return c;
  endfunction

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_t            ctrl;
  logic             take;

  assign ctrl   = ucode(upc_q);
  assign ctrl_o = ctrl;
  assign busy_o = (upc_q != U_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NONE:    take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NOSTART: take = ~start_i;
      C_WRITE:   take = flags_i.is_write;
      C_HIT:     take = flags_i.hit;
      C_MATCH:   take = flags_i.match;
      C_NOMATCH: take = ~flags_i.match;
      default:   take = 1'b0;
    endcase
    if (take) begin
      upc_d = ctrl.jmp;
    end else if (ctrl.hold && !flags_i.last) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // a scan step only repeats while the scan has words left
  a_hold_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.hold && flags_i.last && !take) |=> (upc_q != $past(upc_q)))
    else $error("scan step repeated past its last word");

  // never step into an unused microprogram address
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q <= U_NF)
    else $error("step counter left the microprogram");

  // every emitting step returns to idle
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> (upc_q == U_IDLE))
    else $error("result step did not return to idle");

endmodule

`default_nettype wire

>>> sv/vsc_dpath.sv
// ----------------------------------------------------------------------------
// vsc_dpath
// Datapath: request capture, backing and cache rams, scan counters, match
// counting, block copy, slot valid bits, fifo pointer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              req_type_i,
  input  wire logic [vsc_pkg::ADDR_W-1:0]        ram_addr_i,
  input  wire logic signed [vsc_pkg::DATA_W-1:0] value_i,
  input  wire vsc_pkg::ctrl_t                    ctrl_i,
  output      vsc_pkg::flags_t                   flags_o,
  output      logic                              done_o,
  output      logic [vsc_pkg::STAT_W-1:0]        status_o,
  output      logic [vsc_pkg::CNT_W-1:0]         match_count_o,
  output      logic [vsc_pkg::BLK_W-1:0]         block_number_o,
  output      logic [vsc_pkg::SLOT_W-1:0]        slot_written_o,
  output      logic                              replaced_o
);

  import vsc_pkg::*;

  // captured request
  logic              req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] val_q;

  // scan state
  logic [IW-1:0]  idx_q, idx_d;
  logic [IW-1:0]  rem_q, rem_d;
  logic [GW-1:0]  grp_q, grp_d;
  logic [BWW-1:0] wib_q, wib_d;

  // read in flight
  logic           pend_q;
  logic [GW-1:0]  pgrp_q;
  logic [BWW-1:0] pwib_q;
  logic [IW-1:0]  paddr_q;
  logic           pzero_q;

  // first backing match
  logic [IW-1:0]  hit_addr_q;
  logic [BWW-1:0] hit_wib_q;
  logic [GW-1:0]  hit_grp_q;

  logic [CNT_W-1:0] cnt_q;
  logic [CAW-1:0]   cwa_q;
  logic [GW-1:0]    blk_q;
  logic [SW-1:0]    slot_q;
  logic             repl_q;

  logic [CACHE_SLOTS-1:0] valid_q;
  logic [SW-1:0]          ptr_q;

  // result register
  logic             done_q;
  status_e          status_q;
  logic [CNT_W-1:0] res_cnt_q;
  logic [GW-1:0]    res_blk_q;
  logic [SW-1:0]    res_slot_q;
  logic             res_repl_q;

  // ram ports
  logic [DATA_W-1:0] mem_rdata, cache_rdata, cache_wdata;
  logic              mem_re, mem_we, cache_we;
  logic              rd_any, in_range, wr_ok;
  logic              cache_match, mem_match;
  logic [MAW+ADDR_W-1:0] wr_ext;
  logic [GW+BLK_W-1:0]   blk_ext;
  logic [SW+SLOT_W-1:0]  slot_ext;

  assign wr_ext   = {{MAW{1'b0}}, addr_q};
  assign wr_ok    = (wr_ext < (MAW + ADDR_W)'(MEM_WORDS));
  assign in_range = (idx_q < IW'(MEM_WORDS));
  assign rd_any   = ctrl_i.rd_cache | ctrl_i.rd_mem | ctrl_i.rd_fill;
  assign mem_re   = ctrl_i.rd_mem | (ctrl_i.rd_fill & in_range);
  assign mem_we   = ctrl_i.wr_back & wr_ok;
  assign cache_we = ctrl_i.wr_fill & pend_q;
  // block words past the end of memory are copied as zero
  assign cache_wdata = pzero_q ? '0 : mem_rdata;

  assign cache_match = ctrl_i.cmp_cache & pend_q & valid_q[pgrp_q[SW-1:0]] &
                       (cache_rdata == val_q);
  assign mem_match   = ctrl_i.cmp_mem & pend_q & (mem_rdata == val_q);

  assign flags_o.is_write = ~req_q;
  assign flags_o.hit      = (cnt_q != '0);
  assign flags_o.match    = mem_match;
  assign flags_o.last     = (rem_q == '0);

  vsc_ram #(
    .Width (DATA_W),
    .Depth (MEM_WORDS)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ext[MAW-1:0]),
    .wdata_i (val_q),
    .re_i    (mem_re),
    .raddr_i (idx_q[MAW-1:0]),
    .rdata_o (mem_rdata)
  );

  vsc_ram #(
    .Width (DATA_W),
    .Depth (CACHE_WORDS)
  ) u_cache_ram (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (cwa_q),
    .wdata_i (cache_wdata),
    .re_i    (ctrl_i.rd_cache),
    .raddr_i (idx_q[CAW-1:0]),
    .rdata_o (cache_rdata)
  );

  // scan counters
  always_comb begin
    idx_d = idx_q;
    rem_d = rem_q;
    grp_d = grp_q;
    wib_d = wib_q;
    case (ctrl_i.init)
      INIT_CACHE: begin
        idx_d = '0;
        rem_d = IW'(CACHE_WORDS - 1);
        grp_d = '0;
        wib_d = '0;
      end
      INIT_MEM: begin
        idx_d = '0;
        rem_d = IW'(MEM_WORDS - 1);
        grp_d = '0;
        wib_d = '0;
      end
      INIT_FILL: begin
        idx_d = hit_addr_q - IW'(hit_wib_q);
        rem_d = IW'(BLOCK_WORDS - 1);
        grp_d = '0;
        wib_d = '0;
      end
      default: begin
        if (rd_any) begin
          idx_d = idx_q + 1'b1;
          if (rem_q != '0) begin
            rem_d = rem_q - 1'b1;
          end
          if (wib_q == BWW'(BLOCK_WORDS - 1)) begin
            wib_d = '0;
            grp_d = grp_q + 1'b1;
          end else begin
            wib_d = wib_q + 1'b1;
          end
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      pend_q <= rd_any;
      done_q <= ctrl_i.emit;
      if (ctrl_i.commit) begin
        valid_q[slot_q] <= 1'b1;
        if (slot_q == SW'(CACHE_SLOTS - 1)) begin
          ptr_q <= '0;
        end else begin
          ptr_q <= slot_q + 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q  <= req_type_i;
      addr_q <= ram_addr_i;
      val_q  <= value_i;
    end
    idx_q <= idx_d;
    rem_q <= rem_d;
    grp_q <= grp_d;
    wib_q <= wib_d;
    if (rd_any) begin
      pgrp_q  <= grp_q;
      pwib_q  <= wib_q;
      paddr_q <= idx_q;
      pzero_q <= ctrl_i.rd_fill & ~in_range;
    end
    if (mem_match) begin
      hit_addr_q <= paddr_q;
      hit_wib_q  <= pwib_q;
      hit_grp_q  <= pgrp_q;
    end
    if (ctrl_i.init == INIT_CACHE) begin
      cnt_q <= '0;
    end else if (cache_match && cnt_q != CNT_MAX) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (ctrl_i.init == INIT_FILL) begin
      cwa_q  <= CAW'(int'(ptr_q) * BLOCK_WORDS);
      blk_q  <= hit_grp_q;
      slot_q <= ptr_q;
      repl_q <= valid_q[ptr_q];
    end else if (cache_we) begin
      cwa_q <= cwa_q + 1'b1;
    end
    if (ctrl_i.emit) begin
      status_q   <= ctrl_i.code;
      res_cnt_q  <= (ctrl_i.code == ST_HIT) ? cnt_q : '0;
      res_blk_q  <= (ctrl_i.code == ST_FILLED) ? blk_q : '0;
      res_slot_q <= (ctrl_i.code == ST_FILLED) ? slot_q : '0;
      res_repl_q <= (ctrl_i.code == ST_FILLED) ? repl_q : 1'b0;
    end
  end

  assign blk_ext  = {{BLK_W{1'b0}}, res_blk_q};
  assign slot_ext = {{SLOT_W{1'b0}}, res_slot_q};

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign match_count_o  = res_cnt_q;
  assign block_number_o = blk_ext[BLK_W-1:0];
  assign slot_written_o = slot_ext[SLOT_W-1:0];
  assign replaced_o     = res_repl_q;

  // a fill only writes a slot the pointer named at fill start
  a_fill_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> (slot_q == ptr_q))
    else $error("fifo pointer moved during a block copy");

  // after a commit the written slot is valid
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |=> valid_q[$past(slot_q)])
    else $error("filled slot not marked valid");

  // a cache hit can only count words of valid slots
  a_hit_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cache_match |-> (valid_q != '0))
    else $error("cache match with no valid slot");

endmodule

`default_nettype wire

>>> sv/value_search_cache_fifo_fill.sv
// ----------------------------------------------------------------------------
// value_search_cache_fifo_fill
// Fully associative cache with fifo replacement, searched by value, in front
// of a backing word memory; run by a microprogrammed sequencer.
// ----------------------------------------------------------------------------
// order: a write goes straight to the backing memory; a lookup scans every cache word and
//   reports a hit, or else scans the backing memory and reports not found or, on the first
//   match, copies its block into the fifo slot and reports a fill
// throughput: one item at a time, the next beat taken in the strobe cycle; the cache and
//   backing memory scans read one word a cycle
// reset: slot valid bits and fifo pointer clear at once; the strobe cannot be held off
`default_nettype none

module value_search_cache_fifo_fill (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request beat
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic                              req_type_i,
  input  wire logic [vsc_pkg::ADDR_W-1:0]        ram_addr_i,
  input  wire logic signed [vsc_pkg::DATA_W-1:0] value_i,
  // result beat
  output      logic                              done_o,
  output      logic [vsc_pkg::STAT_W-1:0]        status_o,
  output      logic [vsc_pkg::CNT_W-1:0]         match_count_o,
  output      logic [vsc_pkg::BLK_W-1:0]         block_number_o,
  output      logic [vsc_pkg::SLOT_W-1:0]        slot_written_o,
  output      logic                              replaced_o
);

  import vsc_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   accept;

  // a request beat is taken only while the sequencer sits in idle
  assign accept = start & ~busy;

  // sequencer: microprogram store, step counter and jump logic
  vsc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // datapath: rams, scan counters, match counting and the result register
  vsc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .ram_addr_i     (ram_addr_i),
    .value_i        (value_i),
    .ctrl_i         (ctrl),
    .flags_o        (flags),
    .done_o         (done_o),
    .status_o       (status_o),
    .match_count_o  (match_count_o),
    .block_number_o (block_number_o),
    .slot_written_o (slot_written_o),
    .replaced_o     (replaced_o)
  );

  // an accepted beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not start work");

  // the result beat is shown only once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while still busy");

  // a hit always reports at least one matching word
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_HIT) |-> (match_count_o != '0))
    else $error("cache hit with zero match count");

  // fill fields are zero on every result other than a fill
  a_fill_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_FILLED) |->
      (block_number_o == '0 && slot_written_o == '0 && !replaced_o))
    else $error("fill fields set on a non-fill result");

endmodule

`default_nettype wire
